// ----- rtl/scd_pkg.sv -----
package scd_pkg;

	localparam logic [7:0] PREFIX_BYTE     = 8'hE0;
	localparam logic [7:0] MAP_LAST        = 8'h3A;

	localparam logic [7:0] LSHIFT_MAKE     = 8'h2A;
	localparam logic [7:0] LSHIFT_BREAK    = 8'hAA;
	localparam logic [7:0] RSHIFT_MAKE     = 8'h36;
	localparam logic [7:0] RSHIFT_BREAK    = 8'hB6;
	localparam logic [7:0] ALT_MAKE        = 8'h38;
	localparam logic [7:0] ALT_BREAK       = 8'hB8;
	localparam logic [7:0] CTRL_MAKE       = 8'h1D;
	localparam logic [7:0] CTRL_BREAK      = 8'h9D;
	localparam logic [7:0] CAPS_MAKE       = 8'h3A;
	localparam logic [7:0] CAPS_BREAK      = 8'hBA;

	localparam logic [6:0] LOWER_A         = 7'h61;
	localparam logic [6:0] LOWER_Z         = 7'h7A;
	localparam logic [6:0] CASE_OFFSET     = 7'h20;

	typedef logic [6:0] ascii_t;

	// Unshifted key map, codes 0x00..0x3A; zero marks a key with no character.
	function automatic ascii_t plain_map(input logic [5:0] idx);
		ascii_t c;
		case (idx)
			6'h01: c = 7'h1B;
			6'h02: c = 7'h31;
			6'h03: c = 7'h32;
			6'h04: c = 7'h33;
			6'h05: c = 7'h34;
			6'h06: c = 7'h35;
			6'h07: c = 7'h36;
			6'h08: c = 7'h37;
			6'h09: c = 7'h38;
			6'h0A: c = 7'h39;
			6'h0B: c = 7'h30;
			6'h0C: c = 7'h2D;
			6'h0D: c = 7'h3D;
			6'h0E: c = 7'h08;
			6'h0F: c = 7'h09;
			6'h10: c = 7'h71;
			6'h11: c = 7'h77;
			6'h12: c = 7'h65;
			6'h13: c = 7'h72;
			6'h14: c = 7'h74;
			6'h15: c = 7'h79;
			6'h16: c = 7'h75;
			6'h17: c = 7'h69;
			6'h18: c = 7'h6F;
			6'h19: c = 7'h70;
			6'h1A: c = 7'h5B;
			6'h1B: c = 7'h5D;
			6'h1C: c = 7'h0D;
			6'h1E: c = 7'h61;
			6'h1F: c = 7'h73;
			6'h20: c = 7'h64;
			6'h21: c = 7'h66;
			6'h22: c = 7'h67;
			6'h23: c = 7'h68;
			6'h24: c = 7'h6A;
			6'h25: c = 7'h6B;
			6'h26: c = 7'h6C;
			6'h27: c = 7'h3B;
			6'h28: c = 7'h27;
			6'h29: c = 7'h60;
			6'h2B: c = 7'h5C;
			6'h2C: c = 7'h7A;
			6'h2D: c = 7'h78;
			6'h2E: c = 7'h63;
			6'h2F: c = 7'h76;
			6'h30: c = 7'h62;
			6'h31: c = 7'h6E;
			6'h32: c = 7'h6D;
			6'h33: c = 7'h2C;
			6'h34: c = 7'h2E;
			6'h35: c = 7'h2F;
			6'h37: c = 7'h2A;
			6'h39: c = 7'h20;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

	// Shifted key map, same index range.
	function automatic ascii_t shifted_map(input logic [5:0] idx);
		ascii_t c;
		case (idx)
			6'h01: c = 7'h1B;
			6'h02: c = 7'h21;
			6'h03: c = 7'h40;
			6'h04: c = 7'h23;
			6'h05: c = 7'h24;
			6'h06: c = 7'h25;
			6'h07: c = 7'h5E;
			6'h08: c = 7'h26;
			6'h09: c = 7'h2A;
			6'h0A: c = 7'h28;
			6'h0B: c = 7'h29;
			6'h0C: c = 7'h5F;
			6'h0D: c = 7'h2B;
			6'h0E: c = 7'h08;
			6'h0F: c = 7'h09;
			6'h10: c = 7'h51;
			6'h11: c = 7'h57;
			6'h12: c = 7'h45;
			6'h13: c = 7'h52;
			6'h14: c = 7'h54;
			6'h15: c = 7'h59;
			6'h16: c = 7'h55;
			6'h17: c = 7'h49;
			6'h18: c = 7'h4F;
			6'h19: c = 7'h50;
			6'h1A: c = 7'h7B;
			6'h1B: c = 7'h7D;
			6'h1C: c = 7'h0D;
			6'h1E: c = 7'h41;
			6'h1F: c = 7'h53;
			6'h20: c = 7'h44;
			6'h21: c = 7'h46;
			6'h22: c = 7'h47;
			6'h23: c = 7'h48;
			6'h24: c = 7'h4A;
			6'h25: c = 7'h4B;
			6'h26: c = 7'h4C;
			6'h27: c = 7'h3A;
			6'h28: c = 7'h22;
			6'h29: c = 7'h7E;
			6'h2B: c = 7'h7C;
			6'h2C: c = 7'h5A;
			6'h2D: c = 7'h58;
			6'h2E: c = 7'h43;
			6'h2F: c = 7'h56;
			6'h30: c = 7'h42;
			6'h31: c = 7'h4E;
			6'h32: c = 7'h4D;
			6'h33: c = 7'h3C;
			6'h34: c = 7'h3E;
			6'h35: c = 7'h3F;
			6'h37: c = 7'h2A;
			6'h39: c = 7'h20;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

endpackage

// ----- rtl/scancode_to_ascii_decoder.sv -----
// Scan code set 1 keyboard decoder: each request carries one raw keyboard byte and
// yields exactly one result with the decoded character (char_valid, ascii_char) and the
// shift, ctrl, alt and caps lock flags as they stand after that byte. A 0xE0 byte arms
// the extended prefix; only right alt and right ctrl act on extended codes, and no
// extended code gives a character. Caps lock toggles once per press and affects letters
// only. The block takes one byte every clock cycle unless the output stalls; a result is
// presented once its request has passed the input register and then decode and key map lookup
// into the result register. Backpressure on the output stalls the input only when both
// registers are full and the result is not being taken.
module scancode_to_ascii_decoder
	import scd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,

	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] scan_byte,

	output logic       out_valid,
	input  logic       out_ready,
	output logic       char_valid,
	output logic [6:0] ascii_char,
	output logic       shift_held,
	output logic       ctrl_held,
	output logic       alt_held,
	output logic       caps_on
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;

	logic       prefix_q, shift_q, ctrl_q, alt_q, caps_q, caps_key_q;
	logic       prefix_d, shift_d, ctrl_d, alt_d, caps_d, caps_key_d;
	ascii_t     ch;

	logic       valid_s2;
	logic       char_valid_s2;
	ascii_t     ascii_s2;
	logic       shift_s2, ctrl_s2, alt_s2, caps_s2;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= scan_byte;
		end
	end

	always_comb begin
		prefix_d   = prefix_q;
		shift_d    = shift_q;
		ctrl_d     = ctrl_q;
		alt_d      = alt_q;
		caps_d     = caps_q;
		caps_key_d = caps_key_q;
		ch         = '0;
		if (byte_s1 == PREFIX_BYTE) begin
			prefix_d = 1'b1;
		end else begin
			prefix_d = 1'b0;
			if (prefix_q) begin
				// extended: right alt / right ctrl share the left-side flags
				case (byte_s1)
					ALT_MAKE:   alt_d  = 1'b1;
					ALT_BREAK:  alt_d  = 1'b0;
					CTRL_MAKE:  ctrl_d = 1'b1;
					CTRL_BREAK: ctrl_d = 1'b0;
					default: ;
				endcase
			end else begin
				case (byte_s1)
					LSHIFT_MAKE, RSHIFT_MAKE:     shift_d = 1'b1;
					LSHIFT_BREAK, RSHIFT_BREAK:   shift_d = 1'b0;
					ALT_MAKE:                     alt_d   = 1'b1;
					ALT_BREAK:                    alt_d   = 1'b0;
					CTRL_MAKE:                    ctrl_d  = 1'b1;
					CTRL_BREAK:                   ctrl_d  = 1'b0;
					CAPS_MAKE: begin
						// typematic repeats are ignored until the break code
						if (!caps_key_q) begin
							caps_d     = !caps_q;
							caps_key_d = 1'b1;
						end
					end
					CAPS_BREAK:                   caps_key_d = 1'b0;
					default: ;
				endcase
				if (byte_s1 <= MAP_LAST) begin
					ch = shift_d ? shifted_map(byte_s1[5:0]) : plain_map(byte_s1[5:0]);
					if (caps_d && (ch inside {[LOWER_A:LOWER_Z]})) begin
						ch = ch - CASE_OFFSET;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q   <= 1'b0;
			shift_q    <= 1'b0;
			ctrl_q     <= 1'b0;
			alt_q      <= 1'b0;
			caps_q     <= 1'b0;
			caps_key_q <= 1'b0;
		end else if (advance) begin
			prefix_q   <= prefix_d;
			shift_q    <= shift_d;
			ctrl_q     <= ctrl_d;
			alt_q      <= alt_d;
			caps_q     <= caps_d;
			caps_key_q <= caps_key_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			char_valid_s2 <= (ch != '0);
			ascii_s2      <= ch;
			shift_s2      <= shift_d;
			ctrl_s2       <= ctrl_d;
			alt_s2        <= alt_d;
			caps_s2       <= caps_d;
		end
	end

	assign out_valid  = valid_s2;
	assign char_valid = char_valid_s2;
	assign ascii_char = ascii_s2;
	assign shift_held = shift_s2;
	assign ctrl_held  = ctrl_s2;
	assign alt_held   = alt_s2;
	assign caps_on    = caps_s2;

	a_char_flag: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (char_valid_s2 == (ascii_s2 != '0)))
		else $error("char_valid disagrees with character");

	a_prefix_arm: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && byte_s1 == PREFIX_BYTE) |=> (prefix_q && valid_s2 && !char_valid_s2))
		else $error("prefix byte not handled");

	a_caps_only_on_make: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && !prefix_q && byte_s1 == CAPS_MAKE) |=> $stable(caps_q))
		else $error("caps lock changed without a make code");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && valid_s2 && !out_ready))
		else $error("input stalled without output backpressure");

endmodule
